// ----- src/ngll_pkg.sv -----
package ngll_pkg;

  // Characters that steer the parser.
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_SOUTH   = 8'h53;
  localparam logic [7:0] CHAR_WEST    = 8'h57;

  // Number widths: the fraction store covers up to seven kept digits.
  localparam int INT_W   = 17;
  localparam int FRAC_W  = 24;
  localparam int CNT_W   = 3;
  localparam int MAG_W   = 34;
  localparam int POS_W   = 35;
  localparam int M_W     = 30;
  localparam int Q_W     = 25;
  localparam int REM_W   = 31;

  localparam logic [INT_W-1:0] INT_SAT   = 17'd99999;
  localparam logic [8:0]       HEX_SAT   = 9'd256;
  localparam logic [23:0]      E7        = 24'd10000000;
  // Reciprocal of one hundred scaled by 2^32, rounded up.
  localparam logic [25:0]      RECIP_100 = 26'd42949673;

  typedef enum logic [1:0] {
    NUM_INT,
    NUM_FRAC,
    NUM_DONE
  } ngll_num_phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_QUOT,
    BK_REM,
    BK_SCALE,
    BK_NUM,
    BK_DIV,
    BK_COMMIT
  } ngll_back_state_t;

  // One ended sentence, as handed from the parser to the position unit.
  typedef struct packed {
    logic                        valid;
    logic [7:0]                  sum;
    logic [3:0]                  present;
    logic [1:0]                  hem_neg;
    logic [1:0][INT_W-1:0]       int_part;
    logic [1:0][FRAC_W-1:0]      frac_part;
    logic [1:0][CNT_W-1:0]       frac_cnt;
  } ngll_rec_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } ngll_q_status_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h4C;
      3'd5:    ch = 8'h4C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] k);
    logic [FRAC_W-1:0] p;
    case (k)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

// ----- src/ngll_byte_if.sv -----
interface ngll_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/ngll_result_if.sv -----
interface ngll_result_if;
  logic               valid;
  logic               ready;
  logic               sentence_valid;
  logic signed [34:0] latitude_e7;
  logic signed [34:0] longitude_e7;
  logic [7:0]         computed_sum;

  modport source (output valid, output sentence_valid, output latitude_e7,
                  output longitude_e7, output computed_sum, input ready);
  modport sink (input valid, input sentence_valid, input latitude_e7,
                input longitude_e7, input computed_sum, output ready);
endinterface

// ----- src/nmea_gll_sentence_parser_unit.sv -----
// Takes one byte per cycle; an invalid sentence's result beat goes from its ending
// byte through the queue straight to the result register. A valid sentence's record,
// once taken from the queue, goes through the position unit's steps (divide by
// 100, remainder, scaling, product, 25-step quotient loop, commit).
// A two-entry queue lets the byte side keep running meanwhile; it stalls only
// when two ended sentences wait. Synchronous reset clears parser and held position.
module nmea_gll_sentence_parser_unit #(
  parameter int MAX_SENTENCE    = 128,
  parameter int FRACTION_DIGITS = 5
) (
  input  logic          clk,
  input  logic          rst,
  ngll_byte_if.sink     rx,
  ngll_result_if.source res
);

  ngll_pkg::ngll_rec_t      push_rec;
  ngll_pkg::ngll_rec_t      pop_rec;
  ngll_pkg::ngll_q_status_t qs;
  logic                     push;
  logic                     pop;

  ngll_front #(
    .MAX_SENTENCE    (MAX_SENTENCE),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .qs   (qs),
    .push (push),
    .rec  (push_rec)
  );

  ngll_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .qs       (qs)
  );

  ngll_back u_back (
    .clk (clk),
    .rst (rst),
    .rec (pop_rec),
    .qs  (qs),
    .pop (pop),
    .res (res)
  );

  // The parser must never end a sentence into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qs.full)
    else $error("sentence record pushed into full queue");

  // Records are only taken when present.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> qs.not_empty)
    else $error("record popped from empty queue");

  // Byte side stalls only for a full queue.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> qs.full)
    else $error("byte side stalled without a full queue");

  // Reported latitudes stay within the coordinate range.
  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.latitude_e7 <= 35'sd10006666665) &&
                  (res.latitude_e7 >= -35'sd10006666665))
    else $error("latitude out of range");

endmodule

// ----- src/ngll_front.sv -----
module ngll_front #(
  parameter int MAX_SENTENCE    = 128,
  parameter int FRACTION_DIGITS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  ngll_byte_if.sink              rx,
  input  ngll_pkg::ngll_q_status_t qs,
  output logic                   push,
  output ngll_pkg::ngll_rec_t    rec
);

  localparam int CW = $clog2(MAX_SENTENCE);
  localparam logic [CW-1:0] LAST = CW'(MAX_SENTENCE - 1);

  logic                                capturing, capturing_next;
  logic [CW-1:0]                       byte_count, byte_count_next;
  logic [7:0]                          running_xor, running_xor_next;
  logic                                prefix_ok, prefix_ok_next;
  logic                                star_seen, star_seen_next;
  logic                                hex_open, hex_open_next;
  logic                                text_over, text_over_next;
  logic [8:0]                          hex_value, hex_value_next;
  logic [1:0]                          hex_digits_seen, hex_digits_seen_next;
  logic [2:0]                          field_number, field_number_next;
  logic                                in_field, in_field_next;
  logic [1:0][ngll_pkg::INT_W-1:0]     int_accum, int_accum_next;
  logic [1:0][ngll_pkg::FRAC_W-1:0]    frac_accum, frac_accum_next;
  logic [1:0][ngll_pkg::CNT_W-1:0]     frac_count, frac_count_next;
  ngll_pkg::ngll_num_phase_t           num_phase [2];
  ngll_pkg::ngll_num_phase_t           num_phase_next [2];
  logic [1:0]                          hem_neg, hem_neg_next;
  logic [3:0]                          field_present, field_present_next;

  logic       fire;
  logic [7:0] c;
  logic [12:0] hex_sum;
  logic [20:0] int_sum;
  logic        k;

  // The parser never takes a beat it could not queue a result for.
  assign rx.ready = !qs.full;
  assign fire     = rx.valid && rx.ready;
  assign c        = rx.rx_byte;

  // Per-byte parse step: sentence framing, checksum, field split, numbers.
  always_comb begin
    capturing_next       = capturing;
    byte_count_next      = byte_count;
    running_xor_next     = running_xor;
    prefix_ok_next       = prefix_ok;
    star_seen_next       = star_seen;
    hex_open_next        = hex_open;
    text_over_next       = text_over;
    hex_value_next       = hex_value;
    hex_digits_seen_next = hex_digits_seen;
    field_number_next    = field_number;
    in_field_next        = in_field;
    int_accum_next       = int_accum;
    frac_accum_next      = frac_accum;
    frac_count_next      = frac_count;
    num_phase_next       = num_phase;
    hem_neg_next         = hem_neg;
    field_present_next   = field_present;
    push                 = 1'b0;
    hex_sum              = '0;
    int_sum              = '0;
    k                    = 1'b0;

    if (fire) begin
      if (c == ngll_pkg::CHAR_DOLLAR) begin
        capturing_next       = 1'b1;
        byte_count_next      = '0;
        running_xor_next     = '0;
        prefix_ok_next       = 1'b1;
        star_seen_next       = 1'b0;
        hex_open_next        = 1'b0;
        text_over_next       = 1'b0;
        hex_value_next       = '0;
        hex_digits_seen_next = '0;
        field_number_next    = '0;
        in_field_next        = 1'b1;
        int_accum_next       = '0;
        frac_accum_next      = '0;
        frac_count_next      = '0;
        num_phase_next[0]    = ngll_pkg::NUM_INT;
        num_phase_next[1]    = ngll_pkg::NUM_INT;
        hem_neg_next         = '0;
        field_present_next   = '0;
      end

      if (capturing_next) begin
        if (byte_count_next < LAST) begin
          if (!text_over_next) begin
            if (byte_count_next < CW'(6) &&
                c != ngll_pkg::prefix_char(byte_count_next[2:0])) begin
              prefix_ok_next = 1'b0;
            end
            if (c == ngll_pkg::CHAR_NUL) begin
              text_over_next = 1'b1;
              hex_open_next  = 1'b0;
            end else begin
              // Checksum text up to the star, then the hex digits after it.
              if (byte_count_next != '0 && !star_seen_next) begin
                if (c == ngll_pkg::CHAR_STAR) begin
                  star_seen_next = 1'b1;
                  hex_open_next  = 1'b1;
                end else begin
                  running_xor_next = running_xor_next ^ c;
                end
              end else if (hex_open_next) begin
                if (!ngll_pkg::is_hex(c)) begin
                  hex_open_next = 1'b0;
                end else begin
                  hex_sum = {hex_value_next, 4'b0000} + 13'(ngll_pkg::hex_nibble(c));
                  hex_value_next = (hex_sum > 13'd255) ? ngll_pkg::HEX_SAT
                                                       : hex_sum[8:0];
                  if (hex_digits_seen_next != 2'd3) begin
                    hex_digits_seen_next = hex_digits_seen_next + 2'd1;
                  end
                end
              end

              // Comma fields, runs of commas merged.
              if (c == ngll_pkg::CHAR_COMMA) begin
                in_field_next = 1'b0;
              end else begin
                if (!in_field_next) begin
                  in_field_next = 1'b1;
                  if (field_number_next != 3'd7) begin
                    field_number_next = field_number_next + 3'd1;
                  end
                  if (field_number_next >= 3'd1 && field_number_next <= 3'd4) begin
                    field_present_next[field_number_next[1:0] - 2'd1] = 1'b1;
                    if (field_number_next == 3'd2 || field_number_next == 3'd4) begin
                      hem_neg_next[field_number_next[2]] =
                        (c == ngll_pkg::CHAR_SOUTH) || (c == ngll_pkg::CHAR_WEST);
                    end
                  end
                end
                // Coordinate digits in ddmm.mmmmm form.
                if (field_number_next == 3'd1 || field_number_next == 3'd3) begin
                  k = field_number_next[1];
                  if (num_phase_next[k] != ngll_pkg::NUM_DONE) begin
                    if (c >= 8'h30 && c <= 8'h39) begin
                      if (num_phase_next[k] == ngll_pkg::NUM_INT) begin
                        int_sum = 21'(int_accum_next[k]) * 21'd10 + 21'(c - 8'h30);
                        int_accum_next[k] = (int_sum > 21'(ngll_pkg::INT_SAT))
                                            ? ngll_pkg::INT_SAT
                                            : int_sum[ngll_pkg::INT_W-1:0];
                      end else if (frac_count_next[k] <
                                   ngll_pkg::CNT_W'(FRACTION_DIGITS)) begin
                        frac_accum_next[k] = ngll_pkg::FRAC_W'(frac_accum_next[k] * 10)
                                             + ngll_pkg::FRAC_W'(c - 8'h30);
                        frac_count_next[k] = frac_count_next[k] + ngll_pkg::CNT_W'(1);
                      end
                    end else if (c == ngll_pkg::CHAR_DOT &&
                                 num_phase_next[k] == ngll_pkg::NUM_INT) begin
                      num_phase_next[k] = ngll_pkg::NUM_FRAC;
                    end else begin
                      num_phase_next[k] = ngll_pkg::NUM_DONE;
                    end
                  end
                end
              end
            end
          end
          byte_count_next = byte_count_next + CW'(1);
        end

        // End of sentence on newline or at the length cap.
        if (c == ngll_pkg::CHAR_NEWLINE || byte_count_next >= LAST) begin
          capturing_next = 1'b0;
          push           = 1'b1;
        end
      end
    end
  end

  // Record handed to the queue.
  always_comb begin
    rec.valid     = prefix_ok_next && (byte_count_next >= CW'(6)) && star_seen_next &&
                    (hex_digits_seen_next != 2'd0) &&
                    (hex_value_next == {1'b0, running_xor_next});
    rec.sum       = running_xor_next;
    rec.present   = field_present_next;
    rec.hem_neg   = hem_neg_next;
    rec.int_part  = int_accum_next;
    rec.frac_part = frac_accum_next;
    rec.frac_cnt  = frac_count_next;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      capturing       <= 1'b0;
      byte_count      <= '0;
      running_xor     <= '0;
      prefix_ok       <= 1'b0;
      star_seen       <= 1'b0;
      hex_open        <= 1'b0;
      text_over       <= 1'b0;
      hex_value       <= '0;
      hex_digits_seen <= '0;
      field_number    <= '0;
      in_field        <= 1'b0;
      int_accum       <= '0;
      frac_accum      <= '0;
      frac_count      <= '0;
      num_phase[0]    <= ngll_pkg::NUM_INT;
      num_phase[1]    <= ngll_pkg::NUM_INT;
      hem_neg         <= '0;
      field_present   <= '0;
    end else begin
      capturing       <= capturing_next;
      byte_count      <= byte_count_next;
      running_xor     <= running_xor_next;
      prefix_ok       <= prefix_ok_next;
      star_seen       <= star_seen_next;
      hex_open        <= hex_open_next;
      text_over       <= text_over_next;
      hex_value       <= hex_value_next;
      hex_digits_seen <= hex_digits_seen_next;
      field_number    <= field_number_next;
      in_field        <= in_field_next;
      int_accum       <= int_accum_next;
      frac_accum      <= frac_accum_next;
      frac_count      <= frac_count_next;
      num_phase       <= num_phase_next;
      hem_neg         <= hem_neg_next;
      field_present   <= field_present_next;
    end
  end

endmodule

// ----- src/ngll_queue.sv -----
module ngll_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  ngll_pkg::ngll_rec_t      push_rec,
  input  logic                     pop,
  output ngll_pkg::ngll_rec_t      pop_rec,
  output ngll_pkg::ngll_q_status_t qs
);

  ngll_pkg::ngll_rec_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign qs.full      = (count == 2'd2);
  assign qs.not_empty = (count != 2'd0);
  assign pop_rec      = slots[rd_ptr];

  // Two-entry ring between parser and position unit.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- src/ngll_back.sv -----
module ngll_back (
  input  logic                     clk,
  input  logic                     rst,
  input  ngll_pkg::ngll_rec_t      rec,
  input  ngll_pkg::ngll_q_status_t qs,
  output logic                     pop,
  ngll_result_if.source            res
);

  ngll_pkg::ngll_back_state_t state, state_next;
  ngll_pkg::ngll_rec_t        cur;

  logic [1:0][9:0]                   q100;
  logic [1:0][6:0]                   rem;
  logic [1:0][ngll_pkg::M_W-1:0]     m;
  logic [1:0][ngll_pkg::M_W-1:0]     dvs;
  logic [1:0][ngll_pkg::MAG_W-1:0]   base;
  logic [1:0][ngll_pkg::REM_W-1:0]   r;
  logic [1:0][ngll_pkg::Q_W-1:0]     lo;
  logic [1:0][ngll_pkg::Q_W-1:0]     quo;
  logic [4:0]                        cnt;
  logic [1:0][ngll_pkg::MAG_W-1:0]   held_mag;
  logic [1:0]                        held_neg;

  logic                              out_free;
  logic                              load_direct;
  logic                              commit;
  logic [1:0][42:0]                  prod_q;
  logic [1:0][53:0]                  prod_num;
  logic [1:0][ngll_pkg::REM_W-1:0]   trial;
  logic [1:0]                        trial_ge;
  logic [1:0][ngll_pkg::MAG_W-1:0]   mag_c;
  logic [1:0]                        neg_c;
  logic [1:0][ngll_pkg::POS_W-1:0]   pos_c;
  logic [1:0][ngll_pkg::POS_W-1:0]   pos_held;

  assign out_free = !res.valid || res.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ngll_pkg::BK_IDLE: begin
        if (qs.not_empty && out_free && rec.valid) begin
          state_next = ngll_pkg::BK_QUOT;
        end
      end
      ngll_pkg::BK_QUOT:  state_next = ngll_pkg::BK_REM;
      ngll_pkg::BK_REM:   state_next = ngll_pkg::BK_SCALE;
      ngll_pkg::BK_SCALE: state_next = ngll_pkg::BK_NUM;
      ngll_pkg::BK_NUM:   state_next = ngll_pkg::BK_DIV;
      ngll_pkg::BK_DIV: begin
        if (cnt == 5'd0) begin
          state_next = ngll_pkg::BK_COMMIT;
        end
      end
      ngll_pkg::BK_COMMIT: begin
        if (out_free) begin
          state_next = ngll_pkg::BK_IDLE;
        end
      end
      default: state_next = ngll_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop         = (state == ngll_pkg::BK_IDLE) && qs.not_empty && out_free;
    load_direct = pop && !rec.valid;
    commit      = (state == ngll_pkg::BK_COMMIT) && out_free;
  end

  // Per-coordinate arithmetic: divide by 100, scale, one quotient bit per step.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      prod_q[k]   = 43'(cur.int_part[k]) * 43'(ngll_pkg::RECIP_100);
      prod_num[k] = 54'(m[k]) * 54'(ngll_pkg::E7);
      trial[k]    = {r[k][ngll_pkg::REM_W-2:0], lo[k][ngll_pkg::Q_W-1]};
      trial_ge[k] = (trial[k] >= ngll_pkg::REM_W'(dvs[k]));
      mag_c[k]    = cur.present[2*k] ? (base[k] + ngll_pkg::MAG_W'(quo[k])) : held_mag[k];
      neg_c[k]    = cur.present[2*k+1] ? cur.hem_neg[k] : held_neg[k];
      pos_c[k]    = neg_c[k] ? (ngll_pkg::POS_W'(0) - {1'b0, mag_c[k]}) : {1'b0, mag_c[k]};
      pos_held[k] = held_neg[k] ? (ngll_pkg::POS_W'(0) - {1'b0, held_mag[k]})
                                : {1'b0, held_mag[k]};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rec;
    end
    for (int k = 0; k < 2; k++) begin
      case (state)
        ngll_pkg::BK_QUOT: begin
          q100[k] <= prod_q[k][41:32];
        end
        ngll_pkg::BK_REM: begin
          rem[k] <= 7'(cur.int_part[k] - (17'(q100[k]) * 17'd100));
        end
        ngll_pkg::BK_SCALE: begin
          m[k]    <= ngll_pkg::M_W'(31'(rem[k]) * 31'(ngll_pkg::pow10(cur.frac_cnt[k])))
                     + ngll_pkg::M_W'(cur.frac_part[k]);
          dvs[k]  <= ngll_pkg::M_W'(ngll_pkg::pow10(cur.frac_cnt[k]) * 30'd60);
          base[k] <= ngll_pkg::MAG_W'(q100[k]) * ngll_pkg::MAG_W'(ngll_pkg::E7);
        end
        ngll_pkg::BK_NUM: begin
          r[k]   <= ngll_pkg::REM_W'(prod_num[k] >> ngll_pkg::Q_W);
          lo[k]  <= prod_num[k][ngll_pkg::Q_W-1:0];
          quo[k] <= '0;
        end
        ngll_pkg::BK_DIV: begin
          r[k]   <= trial_ge[k] ? (trial[k] - ngll_pkg::REM_W'(dvs[k])) : trial[k];
          lo[k]  <= {lo[k][ngll_pkg::Q_W-2:0], 1'b0};
          quo[k] <= {quo[k][ngll_pkg::Q_W-2:0], trial_ge[k]};
        end
        default: begin
        end
      endcase
    end
    if (state == ngll_pkg::BK_NUM) begin
      cnt <= 5'(ngll_pkg::Q_W - 1);
    end else if (state == ngll_pkg::BK_DIV) begin
      cnt <= cnt - 5'd1;
    end
  end

  // Held position and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ngll_pkg::BK_IDLE;
      held_mag <= '0;
      held_neg <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        held_mag <= mag_c;
        held_neg <= neg_c;
      end
    end
  end

  // Result register: a beat waits here until taken; no record is popped while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_direct || commit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      res.sentence_valid <= 1'b0;
      res.latitude_e7    <= $signed(pos_held[0]);
      res.longitude_e7   <= $signed(pos_held[1]);
      res.computed_sum   <= rec.sum;
    end else if (commit) begin
      res.sentence_valid <= 1'b1;
      res.latitude_e7    <= $signed(pos_c[0]);
      res.longitude_e7   <= $signed(pos_c[1]);
      res.computed_sum   <= cur.sum;
    end
  end

endmodule

// ----- dv/nmea_gll_sentence_parser_unit_tb.sv -----
`timescale 1ns / 100ps

module nmea_gll_sentence_parser_unit_tb;

  localparam int SENT_CAP  = 128;
  localparam int FRAC_KEEP = 5;
  localparam int CYCLE_CAP = 400000;

  // Codes for the typed-in validity of a directed row.
  localparam int TYPED_NONE  = 2;
  localparam int TYPED_FALSE = 0;
  localparam int TYPED_TRUE  = 1;

  // Stands for a zero byte in the text of a directed row.
  localparam byte unsigned NUL_MARK = 8'h7E;

  typedef struct {
    logic               ok;
    logic signed [34:0] lat;
    logic signed [34:0] lon;
    logic [7:0]         sum;
  } fix_t;

  // One directed row: its text, ending exactly one sentence, and the typed validity.
  typedef struct {
    string text;
    int    typed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ngll_byte_if   rx ();
  ngll_result_if res ();

  nmea_gll_sentence_parser_unit dut (
    .clk(clk),
    .rst(rst),
    .rx (rx.sink),
    .res(res.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte unsigned stim_bytes[$];
  int           typed_valid[$];
  fix_t         fix_expected[$];
  row_t         rows[$];
  int           fail_count = 0;
  int           fix_count = 0;
  int           byte_pos = 0;
  int           cycle_count = 0;
  int           tail_start = 0;

  // Shadow copy of the parser state.
  bit                        cap_on, pfx_ok, star_hit, hex_open, text_done, in_fld;
  int unsigned               beat_cnt, hex_val, hex_cnt, fld_no;
  byte unsigned              xsum;
  int unsigned               ipart[2], fpart[2], fcnt[2];
  ngll_pkg::ngll_num_phase_t nphase[2];
  bit                        hem_neg[2], hem_held[2], present[4];
  longint                    held_pos[2];

  task automatic open_sentence();
    beat_cnt = 0; xsum = 0; pfx_ok = 1; star_hit = 0; hex_val = 0; hex_cnt = 0;
    hex_open = 0; text_done = 0; fld_no = 0; in_fld = 1;
    for (int k = 0; k < 2; k++) begin
      ipart[k] = 0; fpart[k] = 0; fcnt[k] = 0; nphase[k] = ngll_pkg::NUM_INT;
      hem_neg[k] = 0;
    end
    for (int k = 0; k < 4; k++) present[k] = 0;
  endtask

  task automatic coord_char(int k, byte unsigned c);
    int unsigned v;
    if (nphase[k] == ngll_pkg::NUM_DONE) return;
    if (c >= "0" && c <= "9") begin
      if (nphase[k] == ngll_pkg::NUM_INT) begin
        v = ipart[k] * 10 + (c - "0");
        ipart[k] = (v > 99999) ? 99999 : v;
      end else if (fcnt[k] < FRAC_KEEP) begin
        fpart[k] = fpart[k] * 10 + (c - "0");
        fcnt[k]++;
      end
    end else if (c == ngll_pkg::CHAR_DOT && nphase[k] == ngll_pkg::NUM_INT) begin
      nphase[k] = ngll_pkg::NUM_FRAC;
    end else begin
      nphase[k] = ngll_pkg::NUM_DONE;
    end
  endtask

  function automatic int hex_of(byte unsigned c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic text_byte(byte unsigned c, int unsigned pos);
    string lead;
    int d;
    int unsigned v;
    lead = "$GPGLL";
    if (text_done) return;
    if (pos < 6 && c != lead[pos]) pfx_ok = 0;
    if (c == ngll_pkg::CHAR_NUL) begin
      text_done = 1; hex_open = 0;
      return;
    end
    if (pos >= 1 && !star_hit) begin
      if (c == ngll_pkg::CHAR_STAR) begin
        star_hit = 1; hex_open = 1;
      end else begin
        xsum ^= c;
      end
    end else if (hex_open) begin
      d = hex_of(c);
      if (d < 0) begin
        hex_open = 0;
      end else begin
        v = hex_val * 16 + d;
        hex_val = (v > 255) ? 256 : v;
        if (hex_cnt < 3) hex_cnt++;
      end
    end
    if (c == ngll_pkg::CHAR_COMMA) begin
      in_fld = 0;
      return;
    end
    if (!in_fld) begin
      in_fld = 1;
      if (fld_no < 7) fld_no++;
      if (fld_no >= 1 && fld_no <= 4) begin
        present[fld_no-1] = 1;
        if (fld_no == 2 || fld_no == 4)
          hem_neg[(fld_no-2)>>1] = (c == ngll_pkg::CHAR_SOUTH || c == ngll_pkg::CHAR_WEST);
      end
    end
    if (fld_no == 1 || fld_no == 3) coord_char((fld_no-1)>>1, c);
  endtask

  function automatic longint degrees_e7(int k);
    longint unsigned i, p, num;
    i = ipart[k];
    p = 1;
    for (int n = 0; n < fcnt[k]; n++) p *= 10;
    num = ((i % 100) * p + fpart[k]) * 64'd10000000;
    return longint'((i / 100) * 64'd10000000 + num / (60 * p));
  endfunction

  // Advances the shadow parser by one accepted byte; queues a fix when a sentence ends.
  task automatic parse_byte(byte unsigned c);
    fix_t f;
    bit good;
    longint mag;
    int tv;
    if (c == ngll_pkg::CHAR_DOLLAR) begin
      cap_on = 1;
      open_sentence();
    end
    if (!cap_on) return;
    if (beat_cnt < SENT_CAP - 1) begin
      text_byte(c, beat_cnt);
      beat_cnt++;
    end
    if (c != ngll_pkg::CHAR_NEWLINE && beat_cnt < SENT_CAP - 1) return;
    cap_on = 0;
    good = pfx_ok && beat_cnt >= 6 && star_hit && hex_cnt > 0 && hex_val == xsum;
    if (good) begin
      for (int k = 0; k < 2; k++) begin
        mag = (held_pos[k] < 0) ? -held_pos[k] : held_pos[k];
        if (present[2*k]) mag = degrees_e7(k);
        if (present[2*k+1]) hem_held[k] = hem_neg[k];
        held_pos[k] = hem_held[k] ? -mag : mag;
      end
    end
    if (typed_valid.size() > 0) begin
      tv = typed_valid.pop_front();
      if (tv != TYPED_NONE && tv != int'(good)) begin
        $display("%0t: typed validity mismatch: expected %0d, predicted %0d", $realtime, tv,
                 good);
        fail_count++;
      end
    end
    f.ok = good;
    f.lat = held_pos[0][34:0];
    f.lon = held_pos[1][34:0];
    f.sum = xsum;
    fix_expected.push_back(f);
  endtask

  function automatic string sealed(string body, bit bad);
    byte unsigned x;
    x = 0;
    for (int n = 1; n < body.len(); n++) x ^= body[n];
    if (bad) x ^= 8'h01;
    return $sformatf("%s*%02X\n", body, x);
  endfunction

  // Queues the bytes of a text; the marker character stands for a zero byte.
  task automatic push_text(string s);
    for (int n = 0; n < s.len(); n++)
      stim_bytes.push_back((s[n] == NUL_MARK) ? 8'h00 : s[n]);
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  // Byte side: random idle bursts, none in the tail of the run.
  int gap_left = 0;
  always @(posedge clk) begin
    int nxt;
    if (rst) begin
      rx.valid   <= 1'b0;
      rx.rx_byte <= 8'h00;
    end else begin
      nxt = byte_pos;
      if (rx.valid && rx.ready) begin
        parse_byte(rx.rx_byte);
        nxt = byte_pos + 1;
        byte_pos <= nxt;
      end
      if ((rx.valid && rx.ready) || !rx.valid) begin
        if (gap_left == 0 && nxt < tail_start && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 3);
        if (gap_left > 0) begin
          gap_left--;
          rx.valid <= 1'b0;
        end else if (nxt < stim_bytes.size()) begin
          rx.valid   <= 1'b1;
          rx.rx_byte <= stim_bytes[nxt];
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random stall bursts and the comparison against the oldest fix.
  int stall_left = 0;
  always @(posedge clk) begin
    fix_t e;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        fix_count <= fix_count + 1;
        if (fix_expected.size() == 0) begin
          $display("%0t: unexpected result beat", $realtime);
          fail_count++;
        end else begin
          e = fix_expected.pop_front();
          if (res.sentence_valid !== e.ok) begin
            $display("%0t: sentence_valid expected %0d actual %0d", $realtime, e.ok,
                     res.sentence_valid);
            fail_count++;
          end
          if (res.latitude_e7 !== e.lat) begin
            $display("%0t: latitude_e7 expected %0d actual %0d", $realtime, e.lat,
                     res.latitude_e7);
            fail_count++;
          end
          if (res.longitude_e7 !== e.lon) begin
            $display("%0t: longitude_e7 expected %0d actual %0d", $realtime, e.lon,
                     res.longitude_e7);
            fail_count++;
          end
          if (res.computed_sum !== e.sum) begin
            $display("%0t: computed_sum expected %02h actual %02h", $realtime, e.sum,
                     res.computed_sum);
            fail_count++;
          end
        end
      end
      if (stall_left == 0 && byte_pos < tail_start && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 3);
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    string body, s;
    int sentences;
    rx.valid = 1'b0;
    rx.rx_byte = 8'h00;
    res.ready = 1'b0;
    cap_on = 0;
    open_sentence();
    pfx_ok = 0; in_fld = 0;
    hem_held[0] = 0; hem_held[1] = 0;
    held_pos[0] = 0; held_pos[1] = 0;

    // Directed table; each row ends exactly one sentence.
    rows.push_back('{sealed("$GPGLL", 1), TYPED_FALSE});
    rows.push_back('{sealed("$GPGLL,4916.45,N,12311.12,W,225444,A", 0), TYPED_TRUE});
    rows.push_back('{sealed("$GPGLL,4916.45,N,12311.12,W,225444,A", 1), TYPED_FALSE});
    rows.push_back('{sealed("$GPGGA,1234.5,S,00100.0,E", 0), TYPED_FALSE});
    rows.push_back('{"$GP\n", TYPED_FALSE});
    rows.push_back('{"$GPGLL,1,N\n", TYPED_FALSE});
    rows.push_back('{"$GPGLL,1*\n", TYPED_FALSE});
    rows.push_back('{"$GPGLL,1*1FF\n", TYPED_FALSE});
    rows.push_back('{sealed("$GPGLL,9999999.1234567,S,0.0000001,W", 0), TYPED_TRUE});
    rows.push_back('{sealed("$GPGLL,,,1234.5,S", 0), TYPED_TRUE});
    rows.push_back('{{"xyz\n$GPG", sealed("$GPGLL,5000.0,N,00030.5,E", 0)}, TYPED_TRUE});
    rows.push_back('{"$GPG~LL,1,N*00\n", TYPED_FALSE});
    rows.push_back('{"$GPGLL,12.5,N~,junk*00\n", TYPED_NONE});
    s = "$GPGLL,";
    for (int n = 0; n < 125; n++) s = {s, "7"};
    rows.push_back('{s, TYPED_FALSE});
    s = sealed("$GPGLL,0123.4,S,-12.3,W,a,b,c,d,e,f,g", 0);
    s = s.tolower();
    rows.push_back('{{s.substr(0, 6).toupper(), s.substr(7, s.len()-1)}, TYPED_NONE});
    rows.push_back('{$sformatf("$GPGLL,%c%c%c*00\n", 8'hFF, 8'h80, 8'h7F), TYPED_NONE});
    foreach (rows[i]) begin
      push_text(rows[i].text);
      typed_valid.push_back(rows[i].typed);
    end

    // Random part: mostly well-formed sentences with random content.
    sentences = 0;
    while (stim_bytes.size() < 1400 || sentences < 70) begin
      case ($urandom_range(0, 9))
        0: begin
          for (int n = $urandom_range(1, 12); n > 0; n--)
            stim_bytes.push_back(8'($urandom_range(0, 255)));
          push_text("\n");
        end
        1: begin
          push_text("$GPGLL,");
          for (int n = $urandom_range(1, 20); n > 0; n--)
            stim_bytes.push_back(8'($urandom_range(0, 255)));
          push_text("\n");
        end
        default: begin
          body = "$GPGLL";
          if ($urandom_range(0, 4) != 0) body = {body, ",", digits($urandom_range(0, 6)),
                                                 ".", digits($urandom_range(0, 8))};
          if ($urandom_range(0, 4) != 0) body = {body, ",", ($urandom_range(0, 1) ? "S" : "N")};
          if ($urandom_range(0, 4) != 0) body = {body, ",,", digits($urandom_range(0, 6)),
                                                 ".", digits($urandom_range(0, 8))};
          if ($urandom_range(0, 4) != 0) body = {body, ",", ($urandom_range(0, 1) ? "W" : "E")};
          if ($urandom_range(0, 1)) body = {body, ",", digits(6), ",A,D,X"};
          push_text(sealed(body, $urandom_range(0, 7) == 0));
        end
      endcase
      sentences++;
    end
    tail_start = stim_bytes.size() - 150;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (byte_pos == stim_bytes.size() && fix_expected.size() == 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d bytes, %0d sentence results: prefixes, checksums, caps, restarts,",
             stim_bytes.size(), fix_count);
    $display("zero bytes, merged fields, saturation and hemisphere signs.");
    if (fail_count == 0 && fix_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
